[rtl/cd_pkg.sv]
// ----------------------------------------------------------------------------
// cd_pkg
// Shared field widths and action codes for the circular deque.
// ----------------------------------------------------------------------------
`default_nettype none

package cd_pkg;

  localparam int unsigned KindW  = 3;
  localparam int unsigned WordW  = 32;
  localparam int unsigned LimitW = 5;
  localparam int unsigned TotalW = 5;

  // action codes carried in s_axis_tuser
  localparam logic [KindW-1:0] KIND_INS_FRONT = 3'd0;
  localparam logic [KindW-1:0] KIND_INS_BACK  = 3'd1;
  localparam logic [KindW-1:0] KIND_REM_FRONT = 3'd2;
  localparam logic [KindW-1:0] KIND_REM_BACK  = 3'd3;
  localparam logic [KindW-1:0] KIND_REPORT    = 3'd4;

  // result beat: ok, front, back, empty, full, total (low bit first)
  localparam int unsigned ResultW = 1 + 2 * WordW + 1 + 1 + TotalW;

endpackage

`default_nettype wire

[rtl/circular_deque.sv]
// ----------------------------------------------------------------------------
// circular_deque
// Bounded double-ended queue of 32-bit signed words in a ring RAM.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: tuser = action kind (0 push front, 1 push back, 2 pop front,
//   3 pop back, 4..7 report only), tdata = word to push.
//   Master stream: one result transaction per input transaction, carrying the
//   ok flag, front/back words after the action (-1 when empty), empty and
//   full flags and the entry count.
//   Config: cfg_we_i writes the capacity limit (clamped to 1..DEPTH); the
//   write only takes effect while the deque holds no entries.
// Timing:
//   An input transaction updates pointers, count and the RAM in its accept
//   cycle, then the two ring words at front and back are read back through
//   the RAM's registered read ports. The result lands in the output register
//   after ST_READ presents the new pointers to the read ports and ST_LOAD
//   takes the registered read data, once the output register is free.
//   A new item is not accepted until the last result is loaded; tready is low
//   during the read and load states.
// Reset: pointers, count and output valid clear; limit returns to
//   min(16, DEPTH). The RAM is not cleared; entries are shown only once
//   written.
// Stall: the result sits in an output register; a new item is accepted while
//   it waits, and the next result is held in the RAM read stage until the
//   output register frees up.
// ----------------------------------------------------------------------------
`default_nettype none

module circular_deque
  import cd_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // capacity limit register
  input  wire logic               cfg_we_i,
  input  wire logic [LimitW-1:0]  cfg_wdata_i,
  // input items
  input  wire logic               s_axis_tvalid,
  output logic                    s_axis_tready,
  input  wire logic [WordW-1:0]   s_axis_tdata,   // [31:0] value
  input  wire logic [KindW-1:0]   s_axis_tuser,   // [2:0] kind
  // results
  output logic                    m_axis_tvalid,
  input  wire logic               m_axis_tready,
  // [0] ok, [32:1] front_value, [64:33] back_value, [65] is_empty,
  // [66] is_full, [71:67] entry_total
  output logic [ResultW-1:0]      m_axis_tdata
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned LimitReset = (DEPTH < 16) ? DEPTH : 16;

  localparam logic [1:0] ST_IDLE = 2'd0;  // ready for an item
  localparam logic [1:0] ST_READ = 2'd1;  // RAM read of front/back in flight
  localparam logic [1:0] ST_LOAD = 2'd2;  // read data valid, load output

  logic [1:0]    state_q, state_d;
  logic [AW-1:0] head_q, head_d;
  logic [AW-1:0] tail_q, tail_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] limit_q, limit_d;
  logic          ok_q, ok_d;

  logic               out_valid_q, out_valid_d;
  logic [ResultW-1:0] out_data_q, out_data_d;

  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [AW-1:0]    back_addr;
  logic [WordW-1:0] front_word, back_word;

  logic          in_fire;
  logic          is_full, is_empty;
  logic [AW-1:0] head_fwd, head_bwd, tail_fwd, tail_bwd;
  logic          load_out;
  logic [LimitW-1:0] cfg_val;

  function automatic logic [AW-1:0] ptr_fwd(input logic [AW-1:0] p);
    ptr_fwd = (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  function automatic logic [AW-1:0] ptr_bwd(input logic [AW-1:0] p);
    ptr_bwd = (p == '0) ? AW'(DEPTH - 1) : p - AW'(1);
  endfunction

  assign head_fwd = ptr_fwd(head_q);
  assign head_bwd = ptr_bwd(head_q);
  assign tail_fwd = ptr_fwd(tail_q);
  assign tail_bwd = ptr_bwd(tail_q);
  assign back_addr = tail_bwd;

  assign is_full  = (count_q >= limit_q);
  assign is_empty = (count_q == '0);

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  // Action decode: pointers, count and the one RAM write.
  always_comb begin
    head_d    = head_q;
    tail_d    = tail_q;
    count_d   = count_q;
    ok_d      = ok_q;
    ram_we    = 1'b0;
    ram_waddr = tail_q;
    if (in_fire) begin
      ok_d = 1'b1;
      unique case (s_axis_tuser)
        KIND_INS_FRONT: begin
          if (is_full) begin
            ok_d = 1'b0;
          end else begin
            head_d    = head_bwd;
            ram_we    = 1'b1;
            ram_waddr = head_bwd;
            count_d   = count_q + CW'(1);
          end
        end
        KIND_INS_BACK: begin
          if (is_full) begin
            ok_d = 1'b0;
          end else begin
            tail_d    = tail_fwd;
            ram_we    = 1'b1;
            ram_waddr = tail_q;
            count_d   = count_q + CW'(1);
          end
        end
        KIND_REM_FRONT: begin
          if (is_empty) begin
            ok_d = 1'b0;
          end else begin
            head_d  = head_fwd;
            count_d = count_q - CW'(1);
          end
        end
        KIND_REM_BACK: begin
          if (is_empty) begin
            ok_d = 1'b0;
          end else begin
            tail_d  = tail_bwd;
            count_d = count_q - CW'(1);
          end
        end
        default: begin
          // report only, unknown codes too
        end
      endcase
    end
  end

  // Capacity limit: clamp to 1..DEPTH, ignored unless empty.
  assign cfg_val = cfg_wdata_i;
  always_comb begin
    limit_d = limit_q;
    if (cfg_we_i && is_empty) begin
      if (cfg_val == '0) begin
        limit_d = CW'(1);
      end else if (int'(cfg_val) > DEPTH) begin
        limit_d = CW'(DEPTH);
      end else begin
        limit_d = CW'(cfg_val);
      end
    end
  end

  // Sequencer
  assign load_out = (state_q == ST_LOAD) && (!out_valid_q || m_axis_tready);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_fire) state_d = ST_READ;
      ST_READ: state_d = ST_LOAD;
      ST_LOAD: if (load_out) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Output register
  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    if (load_out) begin
      out_valid_d = 1'b1;
      out_data_d  = {TotalW'(count_q), is_full, is_empty,
                     is_empty ? {WordW{1'b1}} : back_word,
                     is_empty ? {WordW{1'b1}} : front_word,
                     ok_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      limit_q     <= CW'(LimitReset);
      ok_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      count_q     <= count_d;
      limit_q     <= limit_d;
      ok_q        <= ok_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  // Read ports follow the pointers; data is valid in the cycle after they settle.
  cd_ram #(
    .Width (WordW),
    .Depth (DEPTH)
  ) u_ring (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (ram_waddr),
    .wdata_i   (s_axis_tdata),
    .raddr_a_i (head_q),
    .raddr_b_i (back_addr),
    .rdata_a_o (front_word),
    .rdata_b_o (back_word)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

`default_nettype wire

[rtl/cd_ram.sv]
// ----------------------------------------------------------------------------
// cd_ram
// Generic RAM: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module cd_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_a_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_b_i,
  output logic      [Width-1:0]         rdata_a_o,
  output logic      [Width-1:0]         rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

`default_nettype wire
